FILE: hw/rtl/eqnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqnt_pkg
// Field widths and register indexes shared by the pitch quantizer files.
// ----------------------------------------------------------------------------
package eqnt_pkg;

  localparam int PITCH_W    = 21;
  localparam int VOICE_W    = 4;
  localparam int POUT_W     = 22;
  localparam int NOTE_W     = 11;
  localparam int PC_W       = 6;
  localparam int MASK_W     = 48;
  localparam int DIVCFG_W   = 6;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 48;
  localparam int RESET_DIVISIONS = 12;

  localparam logic [CFG_ADDR_W-1:0] REG_DIVISIONS    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_ENABLED_MASK = 1'b1;

endpackage
`default_nettype wire

FILE: hw/rtl/eqnt_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqnt_in_if
// Pitch sample channel: valid/ready with the sample and its voice number.
// ----------------------------------------------------------------------------
interface eqnt_in_if import eqnt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [PITCH_W-1:0]  pitch_in;
  logic        [VOICE_W-1:0]  voice;

  modport source (output valid, output pitch_in, output voice, input ready);
  modport sink   (input valid, input pitch_in, input voice, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/eqnt_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqnt_out_if
// Quantized note channel: valid/ready with pitch, note, class and voice.
// ----------------------------------------------------------------------------
interface eqnt_out_if import eqnt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [POUT_W-1:0]   pitch_out;
  logic signed [NOTE_W-1:0]   note_index;
  logic        [PC_W-1:0]     pitch_class;
  logic        [VOICE_W-1:0]  voice_out;

  modport source (output valid, output pitch_out, output note_index,
                  output pitch_class, output voice_out, input ready);
  modport sink   (input valid, input pitch_out, input note_index,
                  input pitch_class, input voice_out, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/eqnt_map_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eqnt_map_builder
// Sweeps the segment map: for each half-step segment scans all candidate
// notes one per cycle, then divides out the rounded pitch fraction bit-serially
// and writes {note, fraction} to the map memory.
// ----------------------------------------------------------------------------
module eqnt_map_builder import eqnt_pkg::*; #(
  parameter int MAX_DIVISIONS = 48,
  parameter int FRAC_BITS     = 16,
  localparam int DW   = $clog2(MAX_DIVISIONS + 1),
  localparam int SW   = $clog2(2 * MAX_DIVISIONS),
  localparam int CW   = $clog2(2 * MAX_DIVISIONS) + 1,
  localparam int QF   = FRAC_BITS + 3,
  localparam int WDW  = CW + QF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire logic [DW-1:0]     n_div,
  input  wire logic [MASK_W-1:0] mask,
  output logic                   busy,
  output logic                   wr_en,
  output logic [SW-1:0]          wr_addr,
  output logic [WDW-1:0]         wr_data
);

  localparam int DGW  = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;
  localparam int DVW  = $clog2(2 * MAX_DIVISIONS + 1);
  localparam int NB   = $clog2(3 * MAX_DIVISIONS) + FRAC_BITS + 2;
  localparam int CNTW = $clog2(NB + 1);

  typedef enum logic [2:0] {ST_INIT, ST_SCAN, ST_DIV, ST_WR, ST_DONE} state_t;

  state_t                 state_r;
  logic [SW-1:0]          seg_r;
  logic signed [CW-1:0]   cand_r;
  logic [DGW-1:0]         deg_r;
  logic signed [CW-1:0]   best_r;
  logic [CW+1:0]          best_dist_r;
  logic                   found_r;
  logic [NB-1:0]          num_r;
  logic [DVW-1:0]         rem_r;
  logic [NB-1:0]          q_r;
  logic [CNTW-1:0]        cnt_r;

  logic [MAX_DIVISIONS-1:0] ext_mask;
  logic [MAX_DIVISIONS-1:0] in_scale;
  logic                     any_on;

  for (genvar k = 0; k < MAX_DIVISIONS; k++) begin : g_deg
    if (k < MASK_W) begin : g_in
      assign ext_mask[k] = mask[k];
    end else begin : g_out
      assign ext_mask[k] = 1'b0;
    end
    assign in_scale[k] = (DW'(k) < n_div);
  end
  assign any_on = |(ext_mask & in_scale);

  logic [DW:0]            two_n;
  logic signed [CW-1:0]   last_cand;
  logic signed [CW+1:0]   target;
  logic signed [CW+1:0]   diff;
  logic [CW+1:0]          cand_dist;
  logic                   cand_on;
  logic                   upd;
  logic signed [CW-1:0]   best_c;
  logic [CW:0]            shifted_m;
  logic [DVW:0]           rem_sh;
  logic                   geq;
  logic [NB-1:0]          q_frac;

  always_comb begin
    two_n     = {n_div, 1'b0};
    last_cand = CW'(two_n) - CW'(1);
    target    = (CW+2)'((SW+1)'(seg_r) + (SW+1)'(1) >> 1);
    diff      = target - (CW+2)'(cand_r);
    cand_dist = diff[CW+1] ? (CW+2)'(-diff) : (CW+2)'(diff);
    cand_on   = !any_on || ext_mask[deg_r];
    upd       = cand_on && (!found_r || (cand_dist < best_dist_r));
    best_c    = upd ? cand_r : best_r;
    shifted_m = (CW+1)'(best_c) + (CW+1)'(n_div);
    rem_sh    = {rem_r, num_r[NB-1]};
    geq       = (rem_sh >= (DVW+1)'(two_n));
    q_frac    = q_r - (NB'(1) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      state_r <= ST_INIT;
      seg_r   <= '0;
    end else begin
      case (state_r)
        ST_INIT: begin
          cand_r  <= -CW'(n_div);
          deg_r   <= '0;
          found_r <= 1'b0;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          best_r      <= best_c;
          if (upd) begin
            best_dist_r <= cand_dist;
            found_r     <= 1'b1;
          end
          cand_r <= cand_r + CW'(1);
          deg_r  <= (DW'(deg_r) == n_div - DW'(1)) ? '0 : deg_r + DGW'(1);
          if (cand_r == last_cand) begin
            // fraction = floor(((m+n) * 2^(F+1) + n) / 2n) - 2^F
            num_r   <= (NB'(shifted_m) << (FRAC_BITS + 1)) + NB'(n_div);
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= '0;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= geq ? DVW'(rem_sh - (DVW+1)'(two_n)) : DVW'(rem_sh);
          q_r   <= {q_r[NB-2:0], geq};
          num_r <= num_r << 1;
          cnt_r <= cnt_r + CNTW'(1);
          if (cnt_r == CNTW'(NB - 1)) begin
            state_r <= ST_WR;
          end
        end
        ST_WR: begin
          if (SW'(seg_r) == SW'(two_n - (DW+1)'(1))) begin
            state_r <= ST_DONE;
          end else begin
            seg_r   <= seg_r + SW'(1);
            state_r <= ST_INIT;
          end
        end
        ST_DONE: begin
          state_r <= ST_DONE;
        end
        default: begin
          state_r <= ST_INIT;
        end
      endcase
    end
  end

  assign busy    = (state_r != ST_DONE);
  assign wr_en   = (state_r == ST_WR);
  assign wr_addr = seg_r;
  assign wr_data = {best_r, q_frac[QF-1:0]};

endmodule
`default_nettype wire

FILE: hw/rtl/edo_pitch_quantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edo_pitch_quantizer
// Snaps a 1 V/octave pitch to the nearest enabled note of an n-tone equal
// division of the octave through a per-segment note map held in memory.
// ----------------------------------------------------------------------------
//   port      dir  handshake     payload
//   in_ch     in   valid/ready   pitch_in, voice
//   out_ch    out  valid/ready   pitch_out, note_index, pitch_class, voice_out
//   cfg_*     in   cfg_we        cfg_addr selects register, cfg_wdata value
//
// One word per cycle unless a map rebuild or a stalled output holds it.
// A word goes through segment multiply and map read into the stage-1
// registers, then note assembly into the output register. After reset and
// after each register write the map is rebuilt, one segment at a time;
// in_ch.ready is low meanwhile. A stalled output holds the whole pipeline.
// ----------------------------------------------------------------------------
module edo_pitch_quantizer import eqnt_pkg::*; #(
  parameter int MAX_DIVISIONS = 48,
  parameter int FRAC_BITS     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  eqnt_in_if.sink                    in_ch,
  eqnt_out_if.source                 out_ch
);

  localparam int DW    = $clog2(MAX_DIVISIONS + 1);
  localparam int SEGS  = 2 * MAX_DIVISIONS;
  localparam int SW    = $clog2(SEGS);
  localparam int CW    = $clog2(SEGS) + 1;
  localparam int QF    = FRAC_BITS + 3;
  localparam int WDW   = CW + QF;
  localparam int DVW   = $clog2(SEGS + 1);
  localparam int PX    = PITCH_W + FRAC_BITS;
  localparam int OW    = (FRAC_BITS < PITCH_W) ? PITCH_W - FRAC_BITS : 1;
  localparam int PW    = ((PITCH_W > QF) ? PITCH_W : QF) + 2;
  localparam int NTW0  = OW + DW + 1;
  localparam int NTW   = ((NTW0 > CW) ? NTW0 : CW) + 1;
  localparam int RST_N = (RESET_DIVISIONS > MAX_DIVISIONS) ? MAX_DIVISIONS
                                                           : RESET_DIVISIONS;
  localparam logic signed [PW-1:0]  POUT_HI = PW'((1 << (POUT_W - 1)) - 1);
  localparam logic signed [PW-1:0]  POUT_LO = -POUT_HI - PW'(1);
  localparam logic signed [NTW-1:0] NOTE_HI = NTW'((1 << (NOTE_W - 1)) - 1);
  localparam logic signed [NTW-1:0] NOTE_LO = -NOTE_HI - NTW'(1);

  // ---------------- configuration ----------------
  logic [DW-1:0]      n_r;
  logic [MASK_W-1:0]  mask_r;
  logic [DIVCFG_W-1:0] div_w;

  assign div_w = cfg_wdata[DIVCFG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= DW'(RST_N);
      mask_r <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DIVISIONS: begin
          if (div_w == '0) begin
            n_r <= DW'(1);
          end else if (int'(div_w) > MAX_DIVISIONS) begin
            n_r <= DW'(MAX_DIVISIONS);
          end else begin
            n_r <= DW'(div_w);
          end
        end
        REG_ENABLED_MASK: mask_r <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- map rebuild ----------------
  logic           busy;
  logic           wr_en;
  logic [SW-1:0]  wr_addr;
  logic [WDW-1:0] wr_data;

  eqnt_map_builder #(
    .MAX_DIVISIONS (MAX_DIVISIONS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_builder (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (cfg_we),
    .n_div   (n_r),
    .mask    (mask_r),
    .busy    (busy),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---------------- stage 0: segment and map read ----------------
  logic                 adv;
  logic                 acc;
  logic signed [PX-1:0] pext;
  logic [FRAC_BITS+DVW-1:0] seg_prod;
  logic [SW-1:0]        rd_addr;
  logic [WDW-1:0]       seg_map [SEGS];
  logic [WDW-1:0]       rdata_r;

  assign adv      = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv && !busy;
  assign acc      = in_ch.valid && in_ch.ready;
  assign pext     = PX'(in_ch.pitch_in);
  assign seg_prod = pext[FRAC_BITS-1:0] * (FRAC_BITS+DVW)'({n_r, 1'b0});
  assign rd_addr  = seg_prod[FRAC_BITS +: SW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seg_map[wr_addr] <= wr_data;
    end
    if (acc) begin
      rdata_r <= seg_map[rd_addr];
    end
  end

  logic                 s1_valid_r;
  logic signed [OW-1:0] s1_oct_r;
  logic [VOICE_W-1:0]   s1_voice_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_oct_r   <= OW'(pext >>> FRAC_BITS);
      s1_voice_r <= in_ch.voice;
    end
  end

  // ---------------- stage 1: note assembly ----------------
  logic signed [CW-1:0]  map_note;
  logic signed [QF-1:0]  map_frac;
  logic signed [NTW-1:0] note;
  logic signed [PW-1:0]  pout;
  logic signed [CW:0]    pc_v;
  logic signed [CW:0]    m_ext;
  logic signed [CW:0]    n_ext;

  always_comb begin
    map_note = rdata_r[QF +: CW];
    map_frac = rdata_r[QF-1:0];
    note  = NTW'(s1_oct_r) * NTW'($signed({1'b0, n_r})) + NTW'(map_note);
    pout  = (PW'(s1_oct_r) <<< FRAC_BITS) + PW'(map_frac);
    m_ext = (CW+1)'(map_note);
    n_ext = (CW+1)'($signed({1'b0, n_r}));
    if (m_ext < 0) begin
      pc_v = m_ext + n_ext;
    end else if (m_ext >= n_ext) begin
      pc_v = m_ext - n_ext;
    end else begin
      pc_v = m_ext;
    end
  end

  // ---------------- output register ----------------
  logic                      out_valid_r;
  logic signed [POUT_W-1:0]  pitch_out_r;
  logic signed [NOTE_W-1:0]  note_index_r;
  logic [PC_W-1:0]           pitch_class_r;
  logic [VOICE_W-1:0]        voice_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      if (pout > POUT_HI) begin
        pitch_out_r <= POUT_W'(POUT_HI);
      end else if (pout < POUT_LO) begin
        pitch_out_r <= POUT_W'(POUT_LO);
      end else begin
        pitch_out_r <= POUT_W'(pout);
      end
      if (note > NOTE_HI) begin
        note_index_r <= NOTE_W'(NOTE_HI);
      end else if (note < NOTE_LO) begin
        note_index_r <= NOTE_W'(NOTE_LO);
      end else begin
        note_index_r <= NOTE_W'(note);
      end
      pitch_class_r <= PC_W'(pc_v);
      voice_out_r   <= s1_voice_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pitch_out   = pitch_out_r;
  assign out_ch.note_index  = note_index_r;
  assign out_ch.pitch_class = pitch_class_r;
  assign out_ch.voice_out   = voice_out_r;

endmodule
`default_nettype wire
